// ===== design/ecal_pkg.sv =====
`timescale 1ns / 1ps

package ecal_pkg;

    localparam int C_SECS_W = 32;
    localparam int C_DAYS_W = 16;
    localparam int C_YEAR_W = 12;
    localparam int C_MONTH_W = 4;
    localparam int C_DOM_W = 5;
    localparam int C_WDAY_W = 3;
    localparam int C_YDAYS_W = 9;

    localparam logic [C_SECS_W-1:0] C_DAY_SECS = 32'd86400;

    // 86400 is 675 << 7: drop the low bits, then multiply by ceil(2^35 / 675)
    localparam int C_DAY_SHIFT = 7;
    localparam int C_QUO_W = C_SECS_W - C_DAY_SHIFT;
    localparam int C_RECIP_W = 26;
    localparam int C_RECIP_SHIFT = 35;
    localparam int C_PROD_W = C_QUO_W + C_RECIP_W;
    localparam logic [C_RECIP_W-1:0] C_DAY_RECIP = 26'd50903317;

    localparam logic [C_YEAR_W-1:0] C_EPOCH_YEAR = 12'd1970;
    localparam logic [1:0] C_EPOCH_MOD4 = 2'd2;
    localparam logic [6:0] C_EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] C_EPOCH_MOD400 = 9'd370;
    localparam logic [6:0] C_MOD100_LAST = 7'd99;
    localparam logic [8:0] C_MOD400_LAST = 9'd399;
    localparam logic [C_WDAY_W-1:0] C_EPOCH_WEEKDAY = 3'd4;

    localparam logic [C_YDAYS_W-1:0] C_DAYS_LEAP = 9'd366;
    localparam logic [C_YDAYS_W-1:0] C_DAYS_PLAIN = 9'd365;

    localparam logic [C_MONTH_W-1:0] C_JAN = 4'd1;
    localparam logic [C_MONTH_W-1:0] C_FEB = 4'd2;
    localparam logic [C_MONTH_W-1:0] C_APR = 4'd4;
    localparam logic [C_MONTH_W-1:0] C_JUN = 4'd6;
    localparam logic [C_MONTH_W-1:0] C_SEP = 4'd9;
    localparam logic [C_MONTH_W-1:0] C_NOV = 4'd11;
    localparam logic [C_MONTH_W-1:0] C_DEC = 4'd12;

    localparam logic [C_DOM_W-1:0] C_MIN_MLEN = 5'd28;

    typedef struct packed {
        logic load;
        logic div_step;
        logic year_step;
        logic month_step;
        logic finish;
    } ecal_cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } ecal_sts_t;

    function automatic logic [C_DOM_W-1:0] month_len(input logic [C_MONTH_W-1:0] m,
                                                      input logic leap);
        logic [C_DOM_W-1:0] len;
        begin
            case (m) inside
                C_APR, C_JUN, C_SEP, C_NOV: len = 5'd30;
                C_FEB: len = leap ? 5'd29 : 5'd28;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // reduce a small value mod 7 by repeated subtraction
    function automatic logic [C_WDAY_W-1:0] mod7(input logic [5:0] v);
        logic [5:0] r;
        begin
            r = v;
            for (int i = 0; i < 5; i++)
            begin
                if (r >= 6'd7)
                begin
                    r = r - 6'd7;
                end
            end
            return r[C_WDAY_W-1:0];
        end
    endfunction

endpackage

// ===== design/ecal_ctrl.sv =====
`timescale 1ns / 1ps

module ecal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ecal_pkg::ecal_sts_t sts,
    output ecal_pkg::ecal_cmd_t cmd,
    output logic               busy,
    output logic               done
);
    import ecal_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_YEAR  = 5'b00100,
        S_MONTH = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (sts.year_fits)
                begin
                    cmd.year_step = 1'b1;
                end
                else
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (sts.month_fits)
                begin
                    cmd.month_step = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== design/ecal_dp.sv =====
`timescale 1ns / 1ps

module ecal_dp (
    input  logic                                  clk,
    input  ecal_pkg::ecal_cmd_t                   cmd,
    input  logic [ecal_pkg::C_SECS_W-1:0]         unix_seconds,
    output ecal_pkg::ecal_sts_t                   sts,
    output logic [ecal_pkg::C_YEAR_W-1:0]         year,
    output logic [ecal_pkg::C_MONTH_W-1:0]        month,
    output logic [ecal_pkg::C_DOM_W-1:0]          day_of_month,
    output logic [ecal_pkg::C_WDAY_W-1:0]         weekday,
    output logic [ecal_pkg::C_WDAY_W-1:0]         first_weekday,
    output logic [ecal_pkg::C_DOM_W-1:0]          month_length
);
    import ecal_pkg::*;

    logic [C_QUO_W-1:0]     secs_reg;
    logic [C_DAYS_W-1:0]    days_reg;
    logic [C_YEAR_W-1:0]    year_reg;
    logic [1:0]             mod4_reg;
    logic [6:0]             mod100_reg;
    logic [8:0]             mod400_reg;
    logic [C_MONTH_W-1:0]   month_reg;
    logic [C_WDAY_W-1:0]    wk_reg;

    logic [C_YEAR_W-1:0]    year_out_reg;
    logic [C_MONTH_W-1:0]   month_out_reg;
    logic [C_DOM_W-1:0]     dom_out_reg;
    logic [C_WDAY_W-1:0]    wday_out_reg;
    logic [C_WDAY_W-1:0]    first_out_reg;
    logic [C_DOM_W-1:0]     mlen_out_reg;

    logic                   leap;
    logic [C_YDAYS_W-1:0]   ydays;
    logic [C_DOM_W-1:0]     mlen;
    logic [C_PROD_W-1:0]    day_prod;
    logic [C_WDAY_W-1:0]    wk_year_next;
    logic [C_WDAY_W-1:0]    wk_month_next;
    logic [C_DOM_W-1:0]     mlen_excess;

    assign leap = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign ydays = leap ? C_DAYS_LEAP : C_DAYS_PLAIN;
    assign mlen = month_len(month_reg, leap);

    // whole days by reciprocal multiply, exact for every 25-bit operand
    assign day_prod = C_PROD_W'(secs_reg) * C_PROD_W'(C_DAY_RECIP);

    // first-day weekday moves by 1 or 2 per year and by len mod 7 per month
    assign wk_year_next = mod7({3'd0, wk_reg} + (leap ? 6'd2 : 6'd1));
    assign mlen_excess = mlen - C_MIN_MLEN;
    assign wk_month_next = mod7({3'd0, wk_reg} + {1'b0, mlen_excess});

    assign sts.year_fits = (days_reg >= {{(C_DAYS_W-C_YDAYS_W){1'b0}}, ydays});
    assign sts.month_fits = (month_reg != C_DEC)
        && (days_reg >= {{(C_DAYS_W-C_DOM_W){1'b0}}, mlen});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            secs_reg <= unix_seconds[C_SECS_W-1:C_DAY_SHIFT];
            days_reg <= '0;
            year_reg <= C_EPOCH_YEAR;
            mod4_reg <= C_EPOCH_MOD4;
            mod100_reg <= C_EPOCH_MOD100;
            mod400_reg <= C_EPOCH_MOD400;
            month_reg <= C_JAN;
            wk_reg <= C_EPOCH_WEEKDAY;
        end
        if (cmd.div_step)
        begin
            days_reg <= day_prod[C_RECIP_SHIFT +: C_DAYS_W];
        end
        if (cmd.year_step)
        begin
            days_reg <= days_reg - {{(C_DAYS_W-C_YDAYS_W){1'b0}}, ydays};
            year_reg <= year_reg + 1'b1;
            mod4_reg <= mod4_reg + 1'b1;
            mod100_reg <= (mod100_reg == C_MOD100_LAST) ? 7'd0 : mod100_reg + 1'b1;
            mod400_reg <= (mod400_reg == C_MOD400_LAST) ? 9'd0 : mod400_reg + 1'b1;
            wk_reg <= wk_year_next;
        end
        if (cmd.month_step)
        begin
            days_reg <= days_reg - {{(C_DAYS_W-C_DOM_W){1'b0}}, mlen};
            month_reg <= month_reg + 1'b1;
            wk_reg <= wk_month_next;
        end
        if (cmd.finish)
        begin
            year_out_reg <= year_reg;
            month_out_reg <= month_reg;
            dom_out_reg <= days_reg[C_DOM_W-1:0] + 1'b1;
            wday_out_reg <= mod7({3'd0, wk_reg} + {1'b0, days_reg[C_DOM_W-1:0]});
            first_out_reg <= wk_reg;
            mlen_out_reg <= mlen;
        end
    end

    assign year = year_out_reg;
    assign month = month_out_reg;
    assign day_of_month = dom_out_reg;
    assign weekday = wday_out_reg;
    assign first_weekday = first_out_reg;
    assign month_length = mlen_out_reg;

endmodule

// ===== design/epoch_seconds_to_calendar_date_top.sv =====
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+---------------------------------------------
// in      | start, busy          | unix_seconds
// out     | done (1-cycle pulse) | year, month, day_of_month, weekday,
//         |                      | first_weekday, month_length
//
// one item at a time: load at the accepting edge, then the day count
// (reciprocal multiply), a year walk with one step per whole year passed
// and a final check, a month walk with one step per whole month passed and
// a final check that captures the results, and the done state; busy is high
// from the day count until the done state ends.
// rst_n clears the controller asynchronously; payload registers are not reset.
// done is high for one cycle and the results hold until the next item ends.

module epoch_seconds_to_calendar_date_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ecal_pkg::C_SECS_W-1:0]   unix_seconds,
    output logic                            done,
    output logic [ecal_pkg::C_YEAR_W-1:0]   year,
    output logic [ecal_pkg::C_MONTH_W-1:0]  month,
    output logic [ecal_pkg::C_DOM_W-1:0]    day_of_month,
    output logic [ecal_pkg::C_WDAY_W-1:0]   weekday,
    output logic [ecal_pkg::C_WDAY_W-1:0]   first_weekday,
    output logic [ecal_pkg::C_DOM_W-1:0]    month_length
);
    import ecal_pkg::*;

    ecal_cmd_t cmd;
    ecal_sts_t sts;

    ecal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ecal_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .unix_seconds  (unix_seconds),
        .sts           (sts),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .weekday       (weekday),
        .first_weekday (first_weekday),
        .month_length  (month_length)
    );

`ifndef SYNTHESIS
    a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> month >= C_JAN && month <= C_DEC && day_of_month <= month_length)
        else $error("result date out of range");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> weekday < 3'd7 && first_weekday < 3'd7)
        else $error("weekday out of range");
`endif

endmodule
